### design/whole_word_match_counter_assert.svh
// Assertion macros used by the word counter RTL.
`ifndef WHOLE_WORD_MATCH_COUNTER_ASSERT_SVH
`define WHOLE_WORD_MATCH_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WWMC_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WWMC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wwmc_pkg.sv
`default_nettype none

package wwmc_pkg;

    // Default maximum word length in bytes.
    localparam int WWMC_MAX_WORD_LENGTH = 10;

    // Number of pattern bytes held by the configuration registers.
    localparam int PATTERN_BYTES = 10;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    // Characters with special meaning.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_QUEST = 8'h3F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Compare results that each window cell reports.
    typedef struct packed {
        logic eq_cur;   // stored byte equals the expected pattern byte
        logic eq_in;    // incoming byte equals the expected pattern byte
        logic sp_cur;   // stored byte is a space
        logic sp_in;    // incoming byte is a space
    } wwmc_cell_flags_t;

    // Map A-Z to a-z, leave everything else alone.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    // Characters allowed right after a word.
    function automatic logic is_terminator(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_LF) || (c == CHAR_NUL) ||
               (c == CHAR_CR) || (c == CHAR_DOT) || (c == CHAR_COMMA) ||
               (c == CHAR_BANG) || (c == CHAR_QUEST) || (c == CHAR_SEMI) ||
               (c == CHAR_COLON);
    endfunction

endpackage

`default_nettype wire

### design/wwmc_cell.sv
`default_nettype none

module wwmc_cell (
    input  wire logic                      aclk,
    input  wire logic                      shift_en,
    input  wire logic [7:0]                in_byte,
    input  wire logic [7:0]                exp_byte,
    output logic [7:0]                     byte_out,
    output wwmc_pkg::wwmc_cell_flags_t     flags
);
    import wwmc_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbor's byte when the window advances.
    assign byte_next = shift_en ? in_byte : byte_reg;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // Local compares for the current and the next window.
    assign flags.eq_cur = (byte_reg == exp_byte);
    assign flags.eq_in  = (in_byte == exp_byte);
    assign flags.sp_cur = (byte_reg == CHAR_SPACE);
    assign flags.sp_in  = (in_byte == CHAR_SPACE);

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

### design/whole_word_match_counter.sv
// Result: the count appears on m_valid in the cycle after the word marked end_of_text
// is accepted.
// Throughput: one text word per cycle; s_ready drops only while a finished count
// waits with m_ready low. The window compare is one level of per-cell compares.
// Reset: synchronous active-low aresetn clears the window control, count and output
// valid, sets the pattern to zero and its length to one; no clearing pass follows.
`default_nettype none
`include "whole_word_match_counter_assert.svh"

module whole_word_match_counter #(
    parameter int MAX_WORD_LENGTH = wwmc_pkg::WWMC_MAX_WORD_LENGTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wwmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [63:0]                       cfg_data,
    // Text input channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_text_byte,
    input  wire logic                              s_end_of_text,
    // Result channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [31:0]                            m_word_count,
    output logic                                   m_count_saturated
);
    import wwmc_pkg::*;

    localparam int NUM_CELLS = MAX_WORD_LENGTH + 1;
    localparam int LEN_W     = $clog2(MAX_WORD_LENGTH + 2);
    localparam logic [LEN_W-1:0] SEEN_MAX = LEN_W'(MAX_WORD_LENGTH + 1);

    // Configuration registers.
    logic [63:0] pattern_low_reg;
    logic [15:0] pattern_high_reg;
    logic [3:0]  pattern_len_reg;

    // Window control and count.
    logic [LEN_W-1:0] seen_reg, seen_next;
    logic [31:0]      total_reg, total_next;
    logic             ended_reg, ended_next;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      out_count_reg, out_count_next;

    logic             accept;
    logic [7:0]       in_lower;
    logic             in_is_nul;
    logic             shift_en;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] seen_inc;
    logic             all_cur, all_in, sp_cur_len, sp_in_len;
    logic             hit_old, hit_new;
    logic [1:0]       hit_inc;
    logic [32:0]      total_sum;
    logic [31:0]      total_upd;

    logic [7:0]       pat_bytes [MAX_WORD_LENGTH];
    logic [7:0]       exp_bytes [NUM_CELLS];
    logic [7:0]       cell_bytes [NUM_CELLS];
    wwmc_cell_flags_t cell_flags [NUM_CELLS];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= 4'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data[15:0];
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Lowercased pattern bytes; bytes past the register range read as zero.
    for (genvar j = 0; j < MAX_WORD_LENGTH; j++) begin : g_pat
        if (j < 8) begin : g_low
            assign pat_bytes[j] = to_lower(pattern_low_reg[8*j +: 8]);
        end else if (j < PATTERN_BYTES) begin : g_high
            assign pat_bytes[j] = to_lower(pattern_high_reg[8*(j-8) +: 8]);
        end else begin : g_none
            assign pat_bytes[j] = CHAR_NUL;
        end
    end

    // Clamp the configured length to MAX_WORD_LENGTH.
    assign len_eff = (int'(pattern_len_reg) > MAX_WORD_LENGTH) ?
                     LEN_W'(MAX_WORD_LENGTH) : LEN_W'(pattern_len_reg);

    // Cell k holds the byte k places back, so it expects pattern byte len-1-k.
    always_comb begin
        for (int k = 0; k < NUM_CELLS; k++) begin
            exp_bytes[k] = CHAR_NUL;
            for (int j = 0; j < MAX_WORD_LENGTH; j++) begin
                if (j + k + 1 == int'(len_eff)) begin
                    exp_bytes[k] = pat_bytes[j];
                end
            end
        end
    end

    // Input handshake and the incoming word.
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign in_lower  = to_lower(s_text_byte);
    assign in_is_nul = (in_lower == CHAR_NUL);
    assign shift_en  = accept && !ended_reg && !in_is_nul;

    // Row of window cells, newest byte in cell 0.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        wwmc_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .in_byte  ((k == 0) ? in_lower : cell_bytes[(k == 0) ? 0 : k - 1]),
            .exp_byte (exp_bytes[k]),
            .byte_out (cell_bytes[k]),
            .flags    (cell_flags[k])
        );
    end

    // Combine the cell compares over the active pattern length.
    always_comb begin
        all_cur    = 1'b1;
        all_in     = 1'b1;
        sp_cur_len = 1'b0;
        sp_in_len  = 1'b0;
        for (int k = 0; k < NUM_CELLS; k++) begin
            if (k < int'(len_eff)) begin
                all_cur = all_cur & cell_flags[k].eq_cur;
                all_in  = all_in & cell_flags[k].eq_in;
            end
            if (k == int'(len_eff)) begin
                sp_cur_len = cell_flags[k].sp_cur;
                sp_in_len  = cell_flags[k].sp_in;
            end
        end
    end

    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + LEN_W'(1);

    // Whole-word hit in the current window and in the window after the shift.
    assign hit_old = (len_eff != '0) && (seen_reg >= len_eff) && all_cur &&
                     ((seen_reg == len_eff) || sp_cur_len);
    assign hit_new = (len_eff != '0) && (seen_inc >= len_eff) && all_in &&
                     ((seen_inc == len_eff) || sp_in_len);

    // A terminator or a NUL can close one hit; a non-NUL final word can also complete another.
    always_comb begin
        hit_inc = 2'd0;
        if (!ended_reg) begin
            if (in_is_nul) begin
                hit_inc = {1'b0, hit_old};
            end else begin
                hit_inc = {1'b0, is_terminator(in_lower) && hit_old} +
                          {1'b0, s_end_of_text && hit_new};
            end
        end
    end

    // Saturating count update.
    assign total_sum = {1'b0, total_reg} + 33'(hit_inc);
    assign total_upd = total_sum[32] ? '1 : total_sum[31:0];

    // Next state of the window control, count and output register.
    always_comb begin
        seen_next      = seen_reg;
        total_next     = total_reg;
        ended_next     = ended_reg;
        out_count_next = out_count_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        if (accept) begin
            if (s_end_of_text) begin
                out_count_next = total_upd;
                m_valid_next   = 1'b1;
                seen_next      = '0;
                total_next     = '0;
                ended_next     = 1'b0;
            end else begin
                total_next = total_upd;
                if (shift_en) begin
                    seen_next = seen_inc;
                end
                if (!ended_reg && in_is_nul) begin
                    ended_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            total_reg   <= '0;
            ended_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            total_reg   <= total_next;
            ended_reg   <= ended_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_count_reg <= out_count_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_word_count      = out_count_reg;
    assign m_count_saturated = &out_count_reg;

    // Checks on the counter's own logic.
    `WWMC_ASSERT_NEXT(a_clear_after_last, aclk, aresetn,
        accept && s_end_of_text,
        m_valid_reg && (seen_reg == '0) && (total_reg == '0) && !ended_reg,
        "Window state not cleared after the final word")
    `WWMC_ASSERT_IMPLIES(a_seen_bound, aclk, aresetn,
        1'b1, seen_reg <= SEEN_MAX,
        "Byte count ran past the window depth")
    `WWMC_ASSERT_IMPLIES(a_no_shift_after_nul, aclk, aresetn,
        ended_reg, !shift_en,
        "Window shifted after the text ended")

endmodule

`default_nettype wire

### tb/sv/whole_word_match_counter_tb.sv
`default_nettype none

module whole_word_match_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wwmc_pkg::*;

    localparam int WINDOW_DEPTH       = WWMC_MAX_WORD_LENGTH + 1;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int SETTLE_CYCLES      = 4;
    localparam int SETTING_COUNT      = 12;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int WORDS_PER_SETTING  = 98;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ALL_ONES = 8'hFF;
    localparam logic [7:0] CHAR_HIGH_BIT = 8'h80;
    localparam logic [7:0] WORD_ENDERS [0:8] = '{CHAR_LF, CHAR_CR, CHAR_DOT, CHAR_COMMA,
        CHAR_BANG, CHAR_QUEST, CHAR_SEMI, CHAR_COLON, CHAR_SPACE};

    typedef struct packed {
        logic [31:0] count;
        logic        saturated;
    } count_result_t;

    // Tracks the counter state and holds the counts still owed by the block.
    class word_count_scoreboard;
        logic [63:0]   pattern_low;
        logic [15:0]   pattern_high;
        logic [3:0]    pattern_len;
        logic [7:0]    window [0:WINDOW_DEPTH-1];
        int unsigned   bytes_seen;
        logic [31:0]   hits;
        bit            text_done;
        count_result_t expected_counts[$];
        int            errors;

        function new();
            pattern_low = '0;
            pattern_high = '0;
            pattern_len = 4'd1;
            errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[i]) window[i] = CHAR_NUL;
            bytes_seen = 0;
            hits = '0;
            text_done = 1'b0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [63:0] data);
            case (index)
                REG_PATTERN_LOW: pattern_low = data;
                REG_PATTERN_HIGH: pattern_high = data[15:0];
                REG_PATTERN_LEN: pattern_len = data[3:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] fold_case(logic [7:0] c);
            return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? (c | CASE_OFFSET) : c;
        endfunction

        // Pattern bytes past the register contents read as NUL and never match.
        function logic [7:0] pattern_char(int k);
            logic [79:0] all_bytes;
            all_bytes = {pattern_high, pattern_low};
            if (k >= PATTERN_BYTES) return CHAR_NUL;
            return fold_case(all_bytes[8*k +: 8]);
        endfunction

        function bit ends_word(logic [7:0] c);
            case (c)
                CHAR_SPACE, CHAR_LF, CHAR_NUL, CHAR_CR, CHAR_DOT, CHAR_COMMA,
                CHAR_BANG, CHAR_QUEST, CHAR_SEMI, CHAR_COLON: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // The pattern ends at the newest byte and starts at text start or after a space.
        function bit window_hit();
            int n;
            int k;
            n = int'(pattern_len);
            if (n == 0) return 1'b0;
            if (n > WWMC_MAX_WORD_LENGTH) n = WWMC_MAX_WORD_LENGTH;
            if (bytes_seen < n) return 1'b0;
            for (k = 0; k < n; k++) begin
                if (window[k] != pattern_char(n - 1 - k)) return 1'b0;
            end
            return (bytes_seen == n) || (window[n] == CHAR_SPACE);
        endfunction

        function void count_hit();
            if (hits != '1) hits++;
        endfunction

        function void note_word(logic [7:0] raw, logic last);
            logic [7:0]    c;
            int            i;
            count_result_t owed;
            c = fold_case(raw);
            if (!text_done) begin
                if (c == CHAR_NUL) begin
                    // A NUL closes the text; everything after it is ignored.
                    if (window_hit()) count_hit();
                    text_done = 1'b1;
                end else begin
                    if (ends_word(c) && window_hit()) count_hit();
                    for (i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
                    window[0] = c;
                    if (bytes_seen < WINDOW_DEPTH) bytes_seen++;
                    // A hit that ends on the final byte still counts.
                    if (last && window_hit()) count_hit();
                end
            end
            if (last) begin
                owed.count = hits;
                owed.saturated = (hits == '1);
                expected_counts.push_back(owed);
                clear_text();
            end
        endfunction

        function void check_result(logic [31:0] count, logic saturated);
            count_result_t want;
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected count word: word_count=%0d count_saturated=%0b",
                         $time, count, saturated);
                errors++;
                return;
            end
            want = expected_counts.pop_front();
            if (count !== want.count) begin
                $display("%0t: word_count mismatch: expected %0d, actual %0d",
                         $time, want.count, count);
                errors++;
            end
            if (saturated !== want.saturated) begin
                $display("%0t: count_saturated mismatch: expected %0b, actual %0b",
                         $time, want.saturated, saturated);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LOW;
    logic [63:0]            cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_text_byte = CHAR_NUL;
    logic                   s_end_of_text = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [31:0]            m_word_count;
    logic                   m_count_saturated;

    word_count_scoreboard sb = new();
    logic [7:0] text_q[$];
    int send_idle = 27;
    int recv_idle = 63;
    int words_sent = 0;
    int stuck_cycles = 0;

    whole_word_match_counter dut (.*);

    always #1 aclk = ~aclk;

    // Result side: check every accepted count word, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_word_count, m_count_saturated);
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: end the run if no channel makes progress for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_word(logic [7:0] b, logic last);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_end_of_text <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(b, last);
        words_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // Let every owed count come back before touching the registers.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(index, data);
    endtask

    // Unused upper bits of the write data carry junk that must be dropped.
    task automatic configure(logic [79:0] pattern, logic [3:0] len);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        write_reg(REG_PATTERN_LOW, pattern[63:0]);
        write_reg(REG_PATTERN_HIGH, {junk[63:16], pattern[79:64]});
        write_reg(REG_PATTERN_LEN, {junk[59:0], len});
        cfg_valid <= 1'b0;
    endtask

    function automatic void queue_str(string s);
        foreach (s[i]) text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = CHAR_UPPER_A + 8'($urandom_range(5));
        if ($urandom_range(1)) c = c + CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (!$urandom_range(1)) return c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CASE_OFFSET;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return c - CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [7:0] pattern_pick();
        int r;
        r = $urandom_range(99);
        if (r < 75) return random_letter();
        if (r < 85) return CHAR_SPACE;
        if (r < 93) return WORD_ENDERS[$urandom_range(8)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [3:0] pick_length(int setting);
        case (setting)
            0: return 4'd1;
            1: return 4'd10;
            2: return 4'd0;
            3: return 4'd15;
            4: return 4'd11;
            default: return ($urandom_range(9) == 0) ? 4'($urandom_range(11, 15))
                                                     : 4'($urandom_range(1, 10));
        endcase
    endfunction

    // Mostly copies of the pattern between spaces and enders, with some noise.
    function automatic void make_text(logic [79:0] pattern, int n);
        int target;
        int r;
        int k;
        target = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
        while (text_q.size() < target) begin
            r = $urandom_range(99);
            if (r < 35) begin
                for (k = 0; k < n; k++) text_q.push_back(flip_case(pattern[8*k +: 8]));
            end else if (r < 50) begin
                text_q.push_back(CHAR_SPACE);
            end else if (r < 62) begin
                text_q.push_back(WORD_ENDERS[$urandom_range(8)]);
            end else if (r < 90) begin
                text_q.push_back(random_letter());
            end else if (r < 93) begin
                text_q.push_back(CHAR_NUL);
            end else begin
                text_q.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    initial begin
        logic [79:0] pattern;
        logic [3:0]  len;
        int          setting;
        int          start;
        int          k;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: reset pattern, then a mixed-case three-letter pattern.
        text_q.push_back(CHAR_ALL_ONES);
        send_text();
        drain();
        configure(80'h5A5A_FF00_4B4B_4B74_4163, 4'd3);
        queue_str("CAT");
        send_text();
        queue_str("cat cAt\r");
        send_text();
        queue_str("cat;cat");
        send_text();
        queue_str("cat");
        text_q.push_back(CHAR_NUL);
        queue_str("x");
        send_text();
        text_q.push_back(CHAR_HIGH_BIT);
        send_text();
        drain();

        // Random texts over several pattern settings and three idling phases.
        for (setting = 0; setting < SETTING_COUNT; setting++) begin
            case (setting / SETTINGS_PER_PHASE)
                0: begin
                    send_idle = 27;
                    recv_idle = 63;
                end
                1: begin
                    send_idle = 63;
                    recv_idle = 27;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (k = 0; k < PATTERN_BYTES; k++) pattern[8*k +: 8] = pattern_pick();
            if (setting == 5) pattern = '1;
            len = pick_length(setting);
            configure(pattern, len);
            start = words_sent;
            while (words_sent - start < WORDS_PER_SETTING) begin
                make_text(pattern,
                          (len > WWMC_MAX_WORD_LENGTH) ? WWMC_MAX_WORD_LENGTH : int'(len));
                send_text();
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
